// ----- hw/rtl/wifi_beacon_element_parser_unit_defines.svh -----
// Assertion macros used by the port checker of the beacon element parser.
`ifndef WIFI_BEACON_ELEMENT_PARSER_UNIT_DEFINES_SVH
`define WIFI_BEACON_ELEMENT_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define WBEP_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define WBEP_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/wbep_pkg.sv -----
// Types, constants and register codes of the beacon element parser.
package wbep_pkg;

	localparam int FCS_BYTES = 4;
	localparam int DL_DEPTH  = (FCS_BYTES > 0) ? FCS_BYTES : 1;
	localparam int FILL_W    = $clog2(FCS_BYTES + 1);

	localparam int FIFO_DEPTH = 8;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] CFG_SSID_OFFSET = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_RATES_TAG   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_TAG = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EXT_TAG     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_IBSS_TAG    = 3'd4;

	localparam logic [7:0] RST_SSID_OFFSET = 8'd36;
	localparam logic [7:0] RST_RATES_TAG   = 8'd1;
	localparam logic [7:0] RST_CHANNEL_TAG = 8'd3;
	localparam logic [7:0] RST_EXT_TAG     = 8'd50;
	localparam logic [7:0] RST_IBSS_TAG    = 8'd6;

	localparam logic KIND_SSID    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	localparam logic [15:0] POS_MAX = 16'hFFFF;

	typedef enum logic [7:0] {
		PH_WAIT  = 8'b0000_0001,
		PH_SLEN  = 8'b0000_0010,
		PH_SSID  = 8'b0000_0100,
		PH_TYPE  = 8'b0000_1000,
		PH_LEN   = 8'b0001_0000,
		PH_FIRST = 8'b0010_0000,
		PH_REST  = 8'b0100_0000,
		PH_IDLE  = 8'b1000_0000
	} phase_t;

	typedef struct packed {
		logic [7:0] ssid_offset;
		logic [7:0] rates_tag;
		logic [7:0] channel_tag;
		logic [7:0] ext_tag;
		logic [7:0] ibss_tag;
	} cfg_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        frame_end;
		logic [15:0] radio_header_length;
		logic        fcs_present;
	} item_t;

	// One byte released past the FCS hold-back, with its frame context.
	typedef struct packed {
		logic        valid;
		logic        have;
		logic [7:0]  data;
		logic [15:0] hdr_len;
		logic        frame_end;
	} rel_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] ssid_char;
		logic [7:0] ssid_length;
		logic [7:0] max_rate;
		logic [7:0] channel_number;
		logic       adhoc_flag;
		logic       run_last;
	} result_t;

	typedef struct packed {
		logic    a_valid;
		result_t a;
		logic    b_valid;
		result_t b;
	} push_t;

endpackage

// ----- hw/rtl/wbep_fcs_align.sv -----
// FCS hold-back line and per-frame sampling of header length and FCS flag.
module wbep_fcs_align import wbep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	input  logic  pos_zero,
	output rel_t  rel
);

	logic [FILL_W-1:0] fill_q, fill_n;
	logic [7:0]        dl_q [DL_DEPTH];
	logic [7:0]        dl_n [DL_DEPTH];
	logic [15:0]       hl_q, hl_n;
	logic              fcs_q, fcs_n;
	logic              first;
	logic [15:0]       hl;
	logic              fcs;

	always_comb begin
		first = pos_zero && (fill_q == '0);
		hl    = first ? item.radio_header_length : hl_q;
		fcs   = first ? item.fcs_present : fcs_q;
		fill_n = fill_q;
		dl_n   = dl_q;
		hl_n   = hl_q;
		fcs_n  = fcs_q;
		rel.valid     = item_valid;
		rel.have      = 1'b0;
		rel.data      = item.data_byte;
		rel.hdr_len   = hl;
		rel.frame_end = item.frame_end;
		if (item_valid) begin
			hl_n  = hl;
			fcs_n = fcs;
			if (fcs && (FCS_BYTES > 0)) begin
				if (fill_q < FILL_W'(FCS_BYTES)) begin
					// still filling: hold the byte back
					for (int i = 0; i < DL_DEPTH; i++) begin
						if (fill_q == FILL_W'(i)) dl_n[i] = item.data_byte;
					end
					fill_n = fill_q + 1'b1;
				end else begin
					rel.have = 1'b1;
					rel.data = dl_q[0];
					for (int i = 0; i < DL_DEPTH - 1; i++) begin
						dl_n[i] = dl_q[i+1];
					end
					dl_n[DL_DEPTH-1] = item.data_byte;
				end
			end else begin
				rel.have = 1'b1;
			end
			if (item.frame_end) begin
				fill_n = '0;
				hl_n   = '0;
				fcs_n  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			hl_q   <= '0;
			fcs_q  <= 1'b0;
		end else begin
			fill_q <= fill_n;
			hl_q   <= hl_n;
			fcs_q  <= fcs_n;
		end
	end

	always_ff @(posedge clk) begin
		dl_q <= dl_n;
	end

endmodule

// ----- hw/rtl/wbep_ie_parse.sv -----
// Element walk: SSID location, rate maximum, DS channel, IBSS flag, summary.
module wbep_ie_parse import wbep_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  rel_t  rel,
	output logic  pos_zero,
	output push_t push
);

	logic [15:0] pos_q, pos_n;
	phase_t      phase_q, phase_n;
	logic [7:0]  etype_q, etype_n;
	logic [7:0]  rem_q, rem_n;
	logic [7:0]  lv_q, lv_n;
	logic [7:0]  slen_q, slen_n;
	logic [7:0]  max_q, max_n;
	logic [7:0]  chan_q, chan_n;
	logic        adhoc_q, adhoc_n;
	logic [16:0] target;
	logic        fin;
	logic        fin_empty;
	logic        emit_ssid;

	assign pos_zero = (pos_q == '0);

	always_comb begin
		pos_n     = pos_q;
		phase_n   = phase_q;
		etype_n   = etype_q;
		rem_n     = rem_q;
		lv_n      = lv_q;
		slen_n    = slen_q;
		max_n     = max_q;
		chan_n    = chan_q;
		adhoc_n   = adhoc_q;
		fin       = 1'b0;
		fin_empty = 1'b0;
		emit_ssid = 1'b0;
		target    = {1'b0, rel.hdr_len} + {9'b0, cfg.ssid_offset};

		if (rel.valid && rel.have) begin
			if (pos_q != POS_MAX) pos_n = pos_q + 16'd1;
			unique case (phase_q)
				PH_WAIT: begin
					if ((target < {1'b0, POS_MAX}) && ({1'b0, pos_q} == target)) begin
						phase_n = PH_SLEN;
					end
				end
				PH_SLEN: begin
					slen_n  = rel.data;
					rem_n   = rel.data;
					phase_n = (rel.data != '0) ? PH_SSID : PH_IDLE;
				end
				PH_SSID: begin
					emit_ssid = 1'b1;
					rem_n     = rem_q - 8'd1;
					if (rem_q == 8'd1) phase_n = PH_TYPE;
				end
				PH_TYPE: begin
					etype_n = rel.data;
					phase_n = PH_LEN;
				end
				PH_LEN: begin
					rem_n = rel.data;
					if (rel.data == '0) begin
						fin       = 1'b1;
						fin_empty = 1'b1;
						phase_n   = PH_TYPE;
					end else begin
						phase_n = PH_FIRST;
					end
				end
				PH_FIRST, PH_REST: begin
					// a DS element keeps its first value byte
					if ((phase_q == PH_FIRST) || (etype_q != cfg.channel_tag)) begin
						lv_n = rel.data;
					end
					rem_n = rem_q - 8'd1;
					if (rem_q == 8'd1) begin
						fin     = 1'b1;
						phase_n = PH_TYPE;
					end else begin
						phase_n = PH_REST;
					end
				end
				PH_IDLE: begin
				end
				default: begin
				end
			endcase
		end

		// close an element; equal tag codes resolve in rates, DS, ext, IBSS order
		if (fin) begin
			if (etype_q == cfg.rates_tag) begin
				if (!fin_empty && (lv_n > max_q)) max_n = lv_n;
			end else if (etype_q == cfg.channel_tag) begin
				if (!fin_empty) chan_n = lv_n;
			end else if (etype_q == cfg.ext_tag) begin
				if (!fin_empty && (lv_n > max_q)) max_n = lv_n;
			end else if (etype_q == cfg.ibss_tag) begin
				adhoc_n = 1'b1;
			end
		end

		push.a_valid          = emit_ssid;
		push.a.kind           = KIND_SSID;
		push.a.ssid_char      = rel.data;
		push.a.ssid_length    = '0;
		push.a.max_rate       = '0;
		push.a.channel_number = '0;
		push.a.adhoc_flag     = 1'b0;
		push.a.run_last       = !rel.frame_end;

		push.b_valid          = rel.valid && rel.frame_end;
		push.b.kind           = KIND_SUMMARY;
		push.b.ssid_char      = '0;
		push.b.ssid_length    = slen_n;
		push.b.max_rate       = max_n;
		push.b.channel_number = chan_n;
		push.b.adhoc_flag     = adhoc_n;
		push.b.run_last       = 1'b1;

		// frame end: clear everything but the channel
		if (rel.valid && rel.frame_end) begin
			pos_n   = '0;
			phase_n = PH_WAIT;
			etype_n = '0;
			rem_n   = '0;
			lv_n    = '0;
			slen_n  = '0;
			max_n   = '0;
			adhoc_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			phase_q <= PH_WAIT;
			etype_q <= '0;
			rem_q   <= '0;
			lv_q    <= '0;
			slen_q  <= '0;
			max_q   <= '0;
			chan_q  <= '0;
			adhoc_q <= 1'b0;
		end else begin
			pos_q   <= pos_n;
			phase_q <= phase_n;
			etype_q <= etype_n;
			rem_q   <= rem_n;
			lv_q    <= lv_n;
			slen_q  <= slen_n;
			max_q   <= max_n;
			chan_q  <= chan_n;
			adhoc_q <= adhoc_n;
		end
	end

endmodule

// ----- hw/rtl/wbep_res_fifo.sv -----
// Result queue taking up to two results a cycle and giving one beat a cycle while pop is high.
module wbep_res_fifo import wbep_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  push_t            push,
	input  logic             pop,
	output result_t          head,
	output logic [CNT_W-1:0] count
);

	result_t          mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             w0_en, w1_en;
	result_t          w0, w1;
	logic [1:0]       n_push;
	logic [PTR_W-1:0] wr1;

	always_comb begin
		w0_en  = push.a_valid || push.b_valid;
		w0     = push.a_valid ? push.a : push.b;
		w1_en  = push.a_valid && push.b_valid;
		w1     = push.b;
		n_push = {1'b0, w0_en} + {1'b0, w1_en};
		wr1    = wr_q + 1'b1;
	end

	assign head  = mem_q[rd_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (w0_en) mem_q[wr_q] <= w0;
		if (w1_en) mem_q[wr1]  <= w1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(n_push);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(n_push) - CNT_W'(pop);
		end
	end

endmodule

// ----- hw/rtl/wifi_beacon_element_parser_unit.sv -----
// Top level of the beacon element parser: input stage, config, parse, result queue.
//
//   channel  handshake             payload
//   s_       s_tvalid / s_tready   tdata: data_byte, radio_header_length; tlast; tuser
//   m_       m_tvalid / m_tready   tdata: ssid fields and summary; tlast; tuser: kind
//   cfg_     cfg_valid / cfg_ready cfg_index, cfg_data
//
// One frame byte a cycle while s_tready holds: a beat is registered in the input
// stage, is parsed there and lands in an eight-entry result queue; the beat after
// it follows directly. s_tready drops when the queue could not hold two results
// for the staged beat and two for the next one. A frame-end beat that also
// releases an SSID byte yields two results and leaves as two output beats.
// arst_n clears all control state and loads the default tags and SSID offset.
module wifi_beacon_element_parser_unit import wbep_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [23:0]          s_tdata,   // [7:0] data_byte, [23:8] radio_header_length
	input  logic                 s_tlast,   // frame_end
	input  logic                 s_tuser,   // fcs_present
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [39:0]          m_tdata,   // ssid_char, ssid_length, max_rate,
	                                        // channel_number, adhoc_flag, zero pad
	output logic                 m_tlast,   // run_last
	output logic                 m_tuser,   // result_kind
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	cfg_t             cfg_q;
	logic             valid_s1;
	item_t            item_s1;
	rel_t             rel;
	logic             pos_zero;
	push_t            push;
	result_t          head;
	logic [CNT_W-1:0] count;
	logic             pop;
	logic [CNT_W:0]   room_need;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ssid_offset <= RST_SSID_OFFSET;
			cfg_q.rates_tag   <= RST_RATES_TAG;
			cfg_q.channel_tag <= RST_CHANNEL_TAG;
			cfg_q.ext_tag     <= RST_EXT_TAG;
			cfg_q.ibss_tag    <= RST_IBSS_TAG;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SSID_OFFSET: cfg_q.ssid_offset <= cfg_data;
				CFG_RATES_TAG:   cfg_q.rates_tag   <= cfg_data;
				CFG_CHANNEL_TAG: cfg_q.channel_tag <= cfg_data;
				CFG_EXT_TAG:     cfg_q.ext_tag     <= cfg_data;
				CFG_IBSS_TAG:    cfg_q.ibss_tag    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// room for two results of the staged beat and two of the next
	assign room_need = {1'b0, count} + (valid_s1 ? (CNT_W+1)'(2) : '0);
	assign s_tready  = room_need <= (CNT_W+1)'(FIFO_DEPTH - 2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= s_tvalid && s_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte           <= s_tdata[7:0];
			item_s1.frame_end           <= s_tlast;
			item_s1.radio_header_length <= s_tdata[23:8];
			item_s1.fcs_present         <= s_tuser;
		end
	end

	wbep_fcs_align u_align (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.item       (item_s1),
		.pos_zero   (pos_zero),
		.rel        (rel)
	);

	wbep_ie_parse u_parse (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.rel      (rel),
		.pos_zero (pos_zero),
		.push     (push)
	);

	assign pop = m_tvalid && m_tready;

	wbep_res_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.count  (count)
	);

	assign m_tvalid = (count != '0);
	assign m_tdata  = {7'b0, head.adhoc_flag, head.channel_number, head.max_rate,
	                   head.ssid_length, head.ssid_char};
	assign m_tlast  = head.run_last;
	assign m_tuser  = head.kind;

endmodule

// ----- hw/rtl/wbep_port_checker.sv -----
// Port-level checker of the beacon element parser and its bind.
`include "wifi_beacon_element_parser_unit_defines.svh"

module wbep_port_checker import wbep_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic        m_tuser
);

	`WBEP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "m_tvalid dropped while stalled")
	`WBEP_ASSERT_NOW(a_summary_last, m_tvalid && (m_tuser == KIND_SUMMARY), m_tlast, "summary beat without tlast")
	`WBEP_ASSERT_NOW(a_ssid_clean, m_tvalid && (m_tuser == KIND_SSID), m_tdata[39:8] == '0, "SSID beat carries summary bits")
	`WBEP_ASSERT_NOW(a_empty_ready, !m_tvalid, s_tready, "input stalled with an empty result queue")

endmodule

bind wifi_beacon_element_parser_unit wbep_port_checker u_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

// ----- verif/wifi_beacon_element_parser_unit_test.sv -----
// Self-checking bench for the beacon element parser: frame bytes in, SSID bytes and summaries out.
`timescale 1ns / 1ps

module wifi_beacon_element_parser_unit_test;
	import wbep_pkg::*;

	localparam int CYCLE_LIMIT  = 2000000;
	localparam int DRAIN_CYCLES = 10;

	typedef logic [7:0] octet_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [23:0]          s_tdata = '0;
	logic                 s_tlast = 1'b0;
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [39:0]          m_tdata;
	logic                 m_tlast;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SSID_OFFSET;
	logic [7:0]           cfg_data = '0;

	wifi_beacon_element_parser_unit uut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	int fails = 0;
	int beats_sent = 0;
	int frames_sent = 0;
	int results_seen = 0;
	int cycle_count = 0;
	int send_gap_pct = 0;
	int recv_stall_pct = 0;

	octet_t frame_bytes [$];

	// Parser mirror: register copy and per-frame state
	cfg_t        reg_set;
	logic [15:0] pos;
	octet_t      fcs_hold [DL_DEPTH];
	int          hold_cnt;
	phase_t      phase;
	octet_t      cur_tag;
	octet_t      remaining;
	octet_t      last_val;
	octet_t      ssid_len_seen;
	octet_t      best_rate;
	octet_t      channel_hold;
	logic        adhoc;
	logic [15:0] frame_hdr_len;
	logic        frame_fcs;
	result_t     ssid_and_summary_q [$];

	function automatic void restart_frame();
		pos = '0;
		foreach (fcs_hold[i])
			fcs_hold[i] = '0;
		hold_cnt = 0;
		phase = PH_WAIT;
		cur_tag = '0;
		remaining = '0;
		last_val = '0;
		ssid_len_seen = '0;
		best_rate = '0;
		adhoc = 1'b0;
		frame_hdr_len = '0;
		frame_fcs = 1'b0;
	endfunction

	// First matching tag wins: rates, channel, extended rates, IBSS
	function automatic void close_element(logic no_value);
		if (cur_tag == reg_set.rates_tag) begin
			if (!no_value && last_val > best_rate)
				best_rate = last_val;
		end else if (cur_tag == reg_set.channel_tag) begin
			if (!no_value)
				channel_hold = last_val;
		end else if (cur_tag == reg_set.ext_tag) begin
			if (!no_value && last_val > best_rate)
				best_rate = last_val;
		end else if (cur_tag == reg_set.ibss_tag) begin
			adhoc = 1'b1;
		end
	endfunction

	function automatic void queue_result(logic kind, octet_t ch);
		result_t r;
		r = '0;
		r.kind = kind;
		if (kind == KIND_SSID) begin
			r.ssid_char = ch;
		end else begin
			r.ssid_length = ssid_len_seen;
			r.max_rate = best_rate;
			r.channel_number = channel_hold;
			r.adhoc_flag = adhoc;
		end
		ssid_and_summary_q.push_back(r);
	endfunction

	function automatic void walk_element_byte(octet_t b);
		logic [15:0] here;
		logic [16:0] ssid_at;
		here = pos;
		if (pos != POS_MAX)
			pos = pos + 16'd1;
		case (phase)
			PH_WAIT: begin
				ssid_at = {1'b0, frame_hdr_len} + {9'd0, reg_set.ssid_offset};
				if (ssid_at < {1'b0, POS_MAX} && {1'b0, here} == ssid_at)
					phase = PH_SLEN;
			end
			PH_SLEN: begin
				ssid_len_seen = b;
				remaining = b;
				phase = (b != 8'd0) ? PH_SSID : PH_IDLE;
			end
			PH_SSID: begin
				queue_result(KIND_SSID, b);
				remaining = remaining - 8'd1;
				if (remaining == 8'd0)
					phase = PH_TYPE;
			end
			PH_TYPE: begin
				cur_tag = b;
				phase = PH_LEN;
			end
			PH_LEN: begin
				remaining = b;
				if (b == 8'd0) begin
					close_element(1'b1);
					phase = PH_TYPE;
				end else begin
					phase = PH_FIRST;
				end
			end
			PH_FIRST, PH_REST: begin
				// channel keeps its first value byte, the rest keep their last
				if (phase == PH_FIRST || cur_tag != reg_set.channel_tag)
					last_val = b;
				remaining = remaining - 8'd1;
				if (remaining == 8'd0) begin
					close_element(1'b0);
					phase = PH_TYPE;
				end else begin
					phase = PH_REST;
				end
			end
			default: ;
		endcase
	endfunction

	function automatic void model_beat(item_t it);
		int      queued_at_entry;
		octet_t  out_byte;
		logic    released;
		result_t r;
		queued_at_entry = ssid_and_summary_q.size();
		released = 1'b0;
		out_byte = '0;
		if (pos == '0 && hold_cnt == 0) begin
			frame_hdr_len = it.radio_header_length;
			frame_fcs = it.fcs_present;
		end
		if (frame_fcs && FCS_BYTES > 0) begin
			if (hold_cnt < FCS_BYTES) begin
				fcs_hold[hold_cnt] = it.data_byte;
				hold_cnt++;
			end else begin
				out_byte = fcs_hold[0];
				for (int i = 0; i < FCS_BYTES - 1; i++)
					fcs_hold[i] = fcs_hold[i + 1];
				fcs_hold[FCS_BYTES - 1] = it.data_byte;
				released = 1'b1;
			end
		end else begin
			out_byte = it.data_byte;
			released = 1'b1;
		end
		if (released)
			walk_element_byte(out_byte);
		if (it.frame_end) begin
			queue_result(KIND_SUMMARY, '0);
			restart_frame();
		end
		if (ssid_and_summary_q.size() > queued_at_entry) begin
			r = ssid_and_summary_q.pop_back();
			r.run_last = 1'b1;
			ssid_and_summary_q.push_back(r);
		end
	endfunction

	task automatic send_beat(item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {it.radio_header_length, it.data_byte};
		s_tlast <= it.frame_end;
		s_tuser <= it.fcs_present;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		model_beat(it);
		beats_sent++;
	endtask

	// Header length and FCS flag only count on the first beat; scramble them elsewhere
	task automatic send_frame(logic [15:0] hdr, logic fcs);
		item_t it;
		foreach (frame_bytes[i]) begin
			it.data_byte = frame_bytes[i];
			it.frame_end = (i == frame_bytes.size() - 1);
			it.radio_header_length = (i == 0) ? hdr : 16'($urandom);
			it.fcs_present = (i == 0) ? fcs : 1'($urandom);
			send_beat(it);
		end
		frames_sent++;
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (ssid_and_summary_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_registers(octet_t offset, octet_t rates, octet_t chan, octet_t ext,
			octet_t ibss);
		logic [CFG_IDX_W-1:0] idx [5];
		octet_t               val [5];
		idx = '{CFG_SSID_OFFSET, CFG_RATES_TAG, CFG_CHANNEL_TAG, CFG_EXT_TAG, CFG_IBSS_TAG};
		val = '{offset, rates, chan, ext, ibss};
		drain();
		for (int k = 0; k < 5; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[k];
			cfg_data <= val[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
			case (idx[k])
				CFG_SSID_OFFSET: reg_set.ssid_offset = val[k];
				CFG_RATES_TAG:   reg_set.rates_tag = val[k];
				CFG_CHANNEL_TAG: reg_set.channel_tag = val[k];
				CFG_EXT_TAG:     reg_set.ext_tag = val[k];
				CFG_IBSS_TAG:    reg_set.ibss_tag = val[k];
				default: ;
			endcase
			cfg_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Well-formed beacon body with random content; optionally cut short before the FCS
	task automatic build_beacon(int hdr, logic fcs, logic cut);
		int     ssid_n;
		int     n_elem;
		int     len;
		int     keep;
		octet_t tag;
		frame_bytes.delete();
		repeat (hdr + reg_set.ssid_offset)
			frame_bytes.push_back(octet_t'($urandom));
		frame_bytes.push_back(octet_t'($urandom));
		if ($urandom_range(7) == 0)
			ssid_n = 0;
		else if ($urandom_range(49) == 0)
			ssid_n = 255;
		else
			ssid_n = $urandom_range(1, 8);
		frame_bytes.push_back(octet_t'(ssid_n));
		repeat (ssid_n)
			frame_bytes.push_back(octet_t'($urandom));
		n_elem = $urandom_range(0, 5);
		repeat (n_elem) begin
			case ($urandom_range(4))
				0: tag = reg_set.rates_tag;
				1: tag = reg_set.channel_tag;
				2: tag = reg_set.ext_tag;
				3: tag = reg_set.ibss_tag;
				default: tag = octet_t'($urandom);
			endcase
			len = ($urandom_range(31) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
			frame_bytes.push_back(tag);
			frame_bytes.push_back(octet_t'(len));
			repeat (len)
				frame_bytes.push_back(octet_t'($urandom));
		end
		if (cut) begin
			keep = $urandom_range(1, frame_bytes.size());
			while (frame_bytes.size() > keep)
				void'(frame_bytes.pop_back());
		end
		if (fcs)
			repeat (FCS_BYTES)
				frame_bytes.push_back(octet_t'($urandom));
	endtask

	task automatic run_frames(int count);
		logic [15:0] hdr;
		logic        fcs;
		repeat (count) begin
			fcs = 1'($urandom);
			if ($urandom_range(4) == 0) begin
				hdr = 16'($urandom);
				frame_bytes.delete();
				repeat ($urandom_range(1, 12))
					frame_bytes.push_back(octet_t'($urandom));
			end else begin
				hdr = 16'($urandom_range(0, 5));
				build_beacon(hdr, fcs, $urandom_range(6) == 0);
			end
			send_frame(hdr, fcs);
		end
	endtask

	task automatic test_register_defaults();
		for (int f = 0; f < 3; f++) begin
			build_beacon(f, f[0], 1'b0);
			send_frame(16'(f), f[0]);
		end
	endtask

	task automatic test_directed_cases();
		write_registers(8'd0, RST_RATES_TAG, RST_CHANNEL_TAG, RST_EXT_TAG, RST_IBSS_TAG);
		// full walk: zero-length DS and rates, rates, DS, zero-length IBSS
		frame_bytes = '{8'h00, 8'd1, 8'h58, RST_CHANNEL_TAG, 8'd0, RST_RATES_TAG, 8'd0,
			RST_RATES_TAG, 8'd1, 8'h8C, RST_CHANNEL_TAG, 8'd1, 8'd11, RST_IBSS_TAG, 8'd0};
		send_frame(16'd0, 1'b0);
		// empty SSID stops the walk; trailing four bytes are FCS
		frame_bytes = '{8'hAA, 8'h00, 8'h00, RST_RATES_TAG, 8'd1, 8'hFF,
			8'hDE, 8'hAD, 8'hBE, 8'hEF};
		send_frame(16'd1, 1'b1);
		// shorter than the FCS
		frame_bytes = '{8'h11, 8'h22, 8'h33};
		send_frame(16'd0, 1'b1);
		// SSID byte on the frame-end beat, SSID cut short by frame end
		frame_bytes = '{8'h00, 8'd3, 8'h61, 8'h62};
		send_frame(16'd0, 1'b0);
		// SSID element past the end of the frame
		frame_bytes = '{8'hFF};
		send_frame(16'hFFFF, 1'b0);
		// extended rates cut off by frame end
		frame_bytes = '{8'h00, 8'd1, 8'h7A, RST_EXT_TAG, 8'd3, 8'h10, 8'h20};
		send_frame(16'd0, 1'b0);
	endtask

	task automatic test_tag_priority();
		octet_t probe [3];
		probe = '{8'd7, 8'd9, 8'd11};
		write_registers(8'd1, 8'd7, 8'd7, 8'd7, 8'd7);
		frame_bytes = '{8'h55, 8'h00, 8'd1, 8'h71, probe[0], 8'd1, 8'h30};
		send_frame(16'd0, 1'b0);
		write_registers(8'd1, RST_RATES_TAG, 8'd9, 8'd9, 8'd9);
		frame_bytes = '{8'h55, 8'h00, 8'd1, 8'h71, probe[1], 8'd1, 8'h30};
		send_frame(16'd0, 1'b0);
		write_registers(8'd1, RST_RATES_TAG, RST_CHANNEL_TAG, 8'd11, 8'd11);
		frame_bytes = '{8'h55, 8'h00, 8'd1, 8'h71, probe[2], 8'd1, 8'h30};
		send_frame(16'd0, 1'b0);
	endtask

	task automatic test_random_frames();
		write_registers(octet_t'($urandom_range(0, 8)), octet_t'($urandom),
			octet_t'($urandom), octet_t'($urandom), octet_t'($urandom));
		run_frames(3);
		send_gap_pct = 87;
		recv_stall_pct = 25;
		write_registers(8'd0, 8'd255, 8'd0, 8'd128, 8'd127);
		run_frames(4);
		write_registers(8'd5, RST_RATES_TAG, RST_CHANNEL_TAG, RST_EXT_TAG, RST_IBSS_TAG);
		run_frames(3);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		write_registers(8'd2, 8'd0, 8'd255, 8'd1, 8'd3);
		run_frames(3);
		write_registers(8'd255, RST_RATES_TAG, RST_CHANNEL_TAG, RST_EXT_TAG, RST_IBSS_TAG);
		run_frames(1);
	endtask

	// Header plus offset runs past the 16-bit position range: the SSID is never found
	task automatic test_far_ssid_position();
		write_registers(8'd255, RST_RATES_TAG, RST_CHANNEL_TAG, RST_EXT_TAG, RST_IBSS_TAG);
		frame_bytes.delete();
		repeat (24)
			frame_bytes.push_back(octet_t'($urandom));
		send_frame(16'hFF10, 1'b0);
	endtask

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fails++;
		end
	endfunction

	always @(posedge clk) begin
		result_t want;
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (ssid_and_summary_q.size() == 0) begin
				$error("unexpected result beat: tdata %h tuser %b tlast %b",
					m_tdata, m_tuser, m_tlast);
				fails++;
			end else begin
				want = ssid_and_summary_q.pop_front();
				check_field("result_kind", want.kind, m_tuser);
				check_field("ssid_char", want.ssid_char, m_tdata[7:0]);
				check_field("ssid_length", want.ssid_length, m_tdata[15:8]);
				check_field("max_rate", want.max_rate, m_tdata[23:16]);
				check_field("channel_number", want.channel_number, m_tdata[31:24]);
				check_field("adhoc_flag", want.adhoc_flag, m_tdata[32]);
				check_field("run_last", want.run_last, m_tlast);
			end
		end
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results pending",
				cycle_count, ssid_and_summary_q.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		reg_set = '{RST_SSID_OFFSET, RST_RATES_TAG, RST_CHANNEL_TAG, RST_EXT_TAG, RST_IBSS_TAG};
		channel_hold = '0;
		restart_frame();
		send_gap_pct = 25;
		recv_stall_pct = 87;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_defaults();
		test_directed_cases();
		test_tag_priority();
		test_random_frames();
		test_far_ssid_position();
		drain();
		$display("Ran %0d frames (%0d beats) and checked %0d result beats",
			frames_sent, beats_sent, results_seen);
		$display("Covered reset and extreme tags, FCS hold-back, cut and empty SSID, far SSID");
		if (fails == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/wbep_pkg.sv
hw/rtl/wbep_fcs_align.sv
hw/rtl/wbep_ie_parse.sv
hw/rtl/wbep_res_fifo.sv
hw/rtl/wifi_beacon_element_parser_unit.sv
hw/rtl/wbep_port_checker.sv
verif/wifi_beacon_element_parser_unit_test.sv
